### rtl/core/dlb_pkg.sv
package dlb_pkg;

  // Fixed field widths
  localparam int VAL_W     = 30;
  localparam int EXP_W     = 31;
  localparam int BLK_W     = 21;
  localparam int CFG_IDX_W = 2;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [EXP_W-1:0] exp_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK   = 2'd2;

  // Operation codes
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_BUILT    = 2'd0;
  localparam logic [1:0] STAT_FOUND    = 2'd1;
  localparam logic [1:0] STAT_NO_SOLN  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RED_BASE,
    S_POW_SQ,
    S_POW_ML,
    S_DIV,
    S_LK_HEAD,
    S_LK_HCHK,
    S_LK_ENT,
    S_LK_ECHK,
    S_INSERT,
    S_STEP_MUL,
    S_Q_RED,
    S_Q_MUL,
    S_DONE
  } dlb_state_t;

  // Modular multiplier request and response
  typedef struct packed {
    logic start;
    val_t a;
    val_t y;
  } mm_req_t;

  typedef struct packed {
    logic done;
    val_t r;
  } mm_rsp_t;

endpackage

### rtl/core/dlb_modmul.sv
module dlb_modmul (
  input  logic             clk,
  input  logic             rst,
  input  dlb_pkg::val_t    modulus,
  input  dlb_pkg::mm_req_t req,
  output dlb_pkg::mm_rsp_t rsp
);
  import dlb_pkg::*;

  localparam int CNT_W = $clog2(VAL_W);

  val_t             a_op;
  val_t             y_op;
  val_t             acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [VAL_W:0]   dbl;
  logic [VAL_W:0]   dbl_red;
  logic [VAL_W:0]   sum;
  logic [VAL_W:0]   sum_red;

  // Double the partial result, then add a if the next multiplier bit is set
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    sum     = dbl_red + (y_op[VAL_W-1] ? {1'b0, a_op} : '0);
    sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
  end

  // Walk the multiplier MSB first, one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VAL_W - 1);
        acc  <= '0;
        a_op <= req.a;
        y_op <= req.y;
      end else if (busy) begin
        acc  <= sum_red[VAL_W-1:0];
        y_op <= {y_op[VAL_W-2:0], 1'b0};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.r    = acc;

endmodule

### rtl/core/discrete_log_bsgs_core.sv
// Discrete logarithm modulo a prime by baby-step giant-step.
// Channels: config write (cfg_valid/cfg_ready, cfg_index, cfg_data), always ready;
// write it only while the core is idle. Input (in_valid/in_ready, operation, target)
// and result (out_valid/out_ready, status, exponent), one result per transaction.
// The core takes one transaction at a time; in_ready is low until its result is taken.
// All modular products go through one bit-serial multiplier.
// Build: sweep the bucket heads, reduce the base, up to 2*30 products for each of
// two modular powers, a restoring division, then per baby step one product plus a
// hash probe along one bucket chain.
// Query: no work if target is 1, else one reduction plus, per giant step, a probe
// and one product, up to modulus/m + 1 steps.
// Reset restores the register defaults and an empty table; a query before any build
// finds only target 1. A stalled receiver holds the result at the output, and the
// core accepts nothing until it is taken.
module discrete_log_bsgs_core #(
  parameter int TABLE_DEPTH  = 1048576,
  parameter int BUCKET_COUNT = 2097152
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dlb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  dlb_pkg::val_t                    cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  dlb_pkg::val_t                    target,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output dlb_pkg::exp_t                    exponent
);
  import dlb_pkg::*;

  localparam int PTR_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int BKT_W = $clog2(BUCKET_COUNT + 1) - 1;
  localparam int NBKT  = 1 << BKT_W;
  localparam int BIT_W = $clog2(VAL_W);

  // Configuration registers
  val_t             base_value;
  val_t             prime_modulus;
  logic [BLK_W-1:0] block_size;

  // Control and datapath registers
  dlb_state_t       state;
  dlb_state_t       state_next;
  logic             mm_run;
  logic             is_query;
  val_t             cur_x;
  logic [PTR_W-1:0] d_cnt;
  logic [PTR_W-1:0] entry_count;
  logic [PTR_W-1:0] head_link;
  logic [PTR_W-1:0] ent_ptr;
  logic [BKT_W-1:0] clr_cnt;
  val_t             base_r;
  val_t             pr;
  val_t             pb;
  val_t             pe;
  logic [BIT_W-1:0] bit_idx;
  logic             pow_sel;
  val_t             dvd;
  val_t             quo;
  logic [PTR_W-1:0] rem_r;
  val_t             giant_factor;
  exp_t             giant_limit;
  val_t             g_r;
  exp_t             step_i;
  exp_t             acc;
  logic [1:0]       status_r;
  exp_t             exponent_r;

  // Memories
  val_t                   baby_value  [TABLE_DEPTH];
  logic [IDX_W-1:0]       baby_index  [TABLE_DEPTH];
  logic [PTR_W-1:0]       chain_next  [TABLE_DEPTH];
  logic [PTR_W-1:0]       bucket_head [NBKT];
  logic [PTR_W-1:0]       head_q;
  val_t                   val_q;
  logic [IDX_W-1:0]       idx_q;
  logic [PTR_W-1:0]       nxt_q;

  // Combinational helpers
  val_t                   n_eff;
  logic [PTR_W-1:0]       m_eff;
  val_t                   cur_key;
  logic [BKT_W-1:0]       cur_bkt;
  logic [IDX_W-1:0]       ent_raddr;
  logic                   ent_hit;
  logic                   last_d;
  logic                   room;
  logic                   last_step;
  dlb_state_t             miss_state;
  logic [PTR_W:0]         rem2;
  logic [PTR_W:0]         rem_sub;
  logic                   rem_ge;
  val_t                   quo_new;
  mm_req_t                mm_req;
  mm_rsp_t                mm_rsp;
  logic                   mm_start;
  logic                   hd_we;
  logic [BKT_W-1:0]       hd_waddr;
  logic [PTR_W-1:0]       hd_wdata;
  logic                   ent_we;
  logic                   in_acc;

  assign in_acc  = in_valid && in_ready;

  // Effective modulus and block size
  always_comb begin
    n_eff = (prime_modulus < VAL_W'(2)) ? VAL_W'(2) : prime_modulus;
    if (block_size == '0) begin
      m_eff = PTR_W'(1);
    end else if (32'(block_size) > 32'(TABLE_DEPTH)) begin
      m_eff = PTR_W'(TABLE_DEPTH);
    end else begin
      m_eff = PTR_W'(block_size);
    end
  end

  assign cur_key    = cur_x;
  assign cur_bkt    = cur_x[BKT_W-1:0];
  assign ent_raddr  = IDX_W'(ent_ptr - PTR_W'(1));
  assign ent_hit    = (val_q == cur_key);
  assign last_d     = ((d_cnt + PTR_W'(1)) == m_eff);
  assign room       = (entry_count < PTR_W'(TABLE_DEPTH));
  assign last_step  = ((step_i + EXP_W'(1)) == giant_limit);
  assign miss_state = is_query ? S_Q_MUL : S_INSERT;

  // One restoring division step
  always_comb begin
    rem2    = {rem_r, dvd[VAL_W-1]};
    rem_ge  = (rem2 >= {1'b0, m_eff});
    rem_sub = rem_ge ? rem2 - {1'b0, m_eff} : rem2;
    quo_new = {quo[VAL_W-2:0], rem_ge};
  end

  dlb_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .modulus (n_eff),
    .req     (mm_req),
    .rsp     (mm_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OP_QUERY) begin
            state_next = (target == VAL_W'(1)) ? S_DONE : S_Q_RED;
          end else begin
            state_next = S_CLEAR;
          end
        end
      end
      S_CLEAR:    if (&clr_cnt) state_next = S_RED_BASE;
      S_RED_BASE: if (mm_rsp.done) state_next = S_POW_SQ;
      S_POW_SQ: begin
        if (mm_rsp.done) begin
          if (pe[bit_idx]) state_next = S_POW_ML;
          else if (bit_idx == '0 && pow_sel) state_next = S_DIV;
          else state_next = S_POW_SQ;
        end
      end
      S_POW_ML: begin
        if (mm_rsp.done) begin
          state_next = (bit_idx == '0 && pow_sel) ? S_DIV : S_POW_SQ;
        end
      end
      S_DIV:     if (bit_idx == '0) state_next = S_LK_HEAD;
      S_LK_HEAD: state_next = S_LK_HCHK;
      S_LK_HCHK: state_next = (head_q == '0) ? miss_state : S_LK_ENT;
      S_LK_ENT:  state_next = S_LK_ECHK;
      S_LK_ECHK: begin
        if (ent_hit) begin
          state_next = (is_query || last_d) ? S_DONE : S_STEP_MUL;
        end else begin
          state_next = (nxt_q == '0) ? miss_state : S_LK_ENT;
        end
      end
      S_INSERT:   state_next = last_d ? S_DONE : S_STEP_MUL;
      S_STEP_MUL: if (mm_rsp.done) state_next = S_LK_HEAD;
      S_Q_RED: begin
        if (mm_rsp.done) state_next = (giant_limit == '0) ? S_DONE : S_LK_HEAD;
      end
      S_Q_MUL: begin
        if (mm_rsp.done) state_next = last_step ? S_DONE : S_LK_HEAD;
      end
      S_DONE:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshakes, multiplier operands, memory writes
  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_DONE);
    mm_start  = 1'b0;
    mm_req.a  = VAL_W'(1);
    mm_req.y  = base_value;
    hd_we     = 1'b0;
    hd_waddr  = cur_bkt;
    hd_wdata  = entry_count + PTR_W'(1);
    ent_we    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_cnt;
        hd_wdata = '0;
      end
      S_RED_BASE: begin
        mm_start = !mm_run;
      end
      S_POW_SQ: begin
        mm_start = !mm_run;
        mm_req.a = pr;
        mm_req.y = pr;
      end
      S_POW_ML: begin
        mm_start = !mm_run;
        mm_req.a = pr;
        mm_req.y = pb;
      end
      S_INSERT: begin
        hd_we  = room;
        ent_we = room;
      end
      S_STEP_MUL: begin
        mm_start = !mm_run;
        mm_req.a = cur_x;
        mm_req.y = base_r;
      end
      S_Q_RED: begin
        mm_start = !mm_run;
        mm_req.y = giant_factor;
      end
      S_Q_MUL: begin
        mm_start = !mm_run;
        mm_req.a = g_r;
        mm_req.y = cur_x;
      end
      default: begin
      end
    endcase
    mm_req.start = mm_start;
  end

  // Bucket heads: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (hd_we) bucket_head[hd_waddr] <= hd_wdata;
    head_q <= bucket_head[cur_bkt];
  end

  // Table entries: written at the fill point, read along the chain
  always_ff @(posedge clk) begin
    if (ent_we) begin
      baby_value[entry_count[IDX_W-1:0]] <= cur_key;
      baby_index[entry_count[IDX_W-1:0]] <= d_cnt[IDX_W-1:0];
      chain_next[entry_count[IDX_W-1:0]] <= head_link;
    end
    val_q <= baby_value[ent_raddr];
    idx_q <= baby_index[ent_raddr];
    nxt_q <= chain_next[ent_raddr];
  end

  // State, configuration and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mm_run        <= 1'b0;
      base_value    <= VAL_W'(1);
      prime_modulus <= VAL_W'(2);
      block_size    <= BLK_W'(1);
      entry_count   <= '0;
      giant_factor  <= VAL_W'(1);
      giant_limit   <= '0;
    end else begin
      state <= state_next;
      // Track one multiply in flight
      if (mm_start) mm_run <= 1'b1;
      else if (mm_rsp.done) mm_run <= 1'b0;
      // Take configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BASE:    base_value    <= cfg_data;
          CFG_MODULUS: prime_modulus <= cfg_data;
          CFG_BLOCK:   block_size    <= cfg_data[BLK_W-1:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            is_query   <= operation;
            cur_x      <= target;
            clr_cnt    <= '0;
            step_i     <= '0;
            acc        <= '0;
            exponent_r <= '0;
            if (operation == OP_QUERY) begin
              status_r <= (target == VAL_W'(1)) ? STAT_FOUND : STAT_NO_SOLN;
            end else begin
              status_r    <= STAT_BUILT;
              entry_count <= '0;
            end
          end
        end
        S_CLEAR: clr_cnt <= clr_cnt + BKT_W'(1);
        S_RED_BASE: begin
          if (mm_rsp.done) begin
            base_r  <= mm_rsp.r;
            pb      <= mm_rsp.r;
            pr      <= VAL_W'(1);
            pe      <= VAL_W'(m_eff);
            bit_idx <= BIT_W'(VAL_W - 1);
            pow_sel <= 1'b0;
          end
        end
        S_POW_SQ, S_POW_ML: begin
          if (mm_rsp.done) begin
            pr <= mm_rsp.r;
            // Advance to the next exponent bit unless a multiply follows
            if (state == S_POW_ML || !pe[bit_idx]) begin
              if (bit_idx == '0) begin
                bit_idx <= BIT_W'(VAL_W - 1);
                if (!pow_sel) begin
                  pb      <= mm_rsp.r;
                  pr      <= VAL_W'(1);
                  pe      <= n_eff - VAL_W'(2);
                  pow_sel <= 1'b1;
                end else begin
                  giant_factor <= mm_rsp.r;
                  dvd          <= n_eff;
                  quo          <= '0;
                  rem_r        <= '0;
                end
              end else begin
                bit_idx <= bit_idx - BIT_W'(1);
              end
            end
          end
        end
        S_DIV: begin
          rem_r   <= rem_sub[PTR_W-1:0];
          quo     <= quo_new;
          dvd     <= {dvd[VAL_W-2:0], 1'b0};
          bit_idx <= bit_idx - BIT_W'(1);
          if (bit_idx == '0) begin
            giant_limit <= EXP_W'(quo_new) + EXP_W'(1);
            cur_x       <= VAL_W'(1);
            d_cnt       <= '0;
          end
        end
        S_LK_HCHK: begin
          head_link <= head_q;
          ent_ptr   <= head_q;
        end
        S_LK_ECHK: begin
          if (ent_hit) begin
            if (is_query) begin
              status_r   <= STAT_FOUND;
              exponent_r <= acc + EXP_W'(idx_q);
            end else begin
              d_cnt <= d_cnt + PTR_W'(1);
            end
          end else begin
            ent_ptr <= nxt_q;
          end
        end
        S_INSERT: begin
          if (room) entry_count <= entry_count + PTR_W'(1);
          d_cnt <= d_cnt + PTR_W'(1);
        end
        S_STEP_MUL: if (mm_rsp.done) cur_x <= mm_rsp.r;
        S_Q_RED:    if (mm_rsp.done) g_r <= mm_rsp.r;
        S_Q_MUL: begin
          if (mm_rsp.done) begin
            cur_x  <= mm_rsp.r;
            step_i <= step_i + EXP_W'(1);
            acc    <= acc + EXP_W'(m_eff);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign status    = status_r;
  assign exponent  = exponent_r;

  // A product completes only in a state that issued one
  a_mm_done_owner: assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> (state == S_RED_BASE || state == S_POW_SQ || state == S_POW_ML ||
                     state == S_STEP_MUL || state == S_Q_RED || state == S_Q_MUL))
    else $error("multiplier result outside a multiply state");

  // The fill point never passes the table depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= PTR_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Accepting a transaction drops ready until its result is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("ready while a transaction is in progress");

endmodule
